### hw/rtl/fhpt_pkg.sv
// Shared types and constants for the file handle position table.
package fhpt_pkg;

   localparam int DATA_W   = 32;
   localparam int ALU_W    = 34;
   localparam int ADDR_W   = 33;
   localparam int HANDLE_W = 5;

   localparam logic [HANDLE_W-1:0] HANDLE_NONE = 5'h1F;

   typedef enum logic [2:0] {
      CMD_OPEN  = 3'd0,
      CMD_SIZE  = 3'd1,
      CMD_TELL  = 3'd2,
      CMD_SEEK  = 3'd3,
      CMD_READ  = 3'd4,
      CMD_CLOSE = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ORG_START   = 2'd0,
      ORG_CURRENT = 2'd1,
      ORG_END     = 2'd2,
      ORG_BAD     = 2'd3
   } origin_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OP1,
      S_SEEK,
      S_CLAMP,
      S_SRC,
      S_ADV
   } state_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

endpackage

### hw/rtl/fhpt_alu.sv
// Shared 34-bit adder/subtractor used by the seek and read steps of the sequencer.
module fhpt_alu
   import fhpt_pkg::*;
(
   input  alu_req_type      alu_req,
   output logic [ALU_W-1:0] alu_sum
);

   logic [ALU_W-1:0] b_eff;

   assign b_eff   = alu_req.sub ? ~alu_req.b : alu_req.b;
   assign alu_sum = alu_req.a + b_eff + {{(ALU_W-1){1'b0}}, alu_req.sub};

endmodule

### hw/rtl/file_handle_position_table.sv
// Top level of the file handle position table: slot storage, sequencer and result register.
//
// Handle table for read-only files with open, size, tell, seek, read and close. A request is
// taken only while the sequencer is idle; req_ready stays low until its result has been
// placed in the result register, which may still hold an untaken result while the next
// request is accepted. The seek and read steps go through one shared 34-bit adder/subtractor.
// Open, size, tell, close, unknown commands and any request turned away for its handle, origin
// or destination finish in the first step (S_OP1); a seek that reaches the range check adds
// S_SEEK, whether or not it is in range, and a read runs S_OP1, S_CLAMP, S_SRC and S_ADV
// (remaining bytes, clamp compare, source address, position advance). A step that completes
// a request waits while the result register is full and not being taken. Slots start unused
// after reset; no clearing pass is needed.
module file_handle_position_table
   import fhpt_pkg::*;
#(
   parameter int HANDLE_SLOTS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_command,
   input  logic signed [HANDLE_W-1:0] req_handle_id,
   input  logic                       req_file_found,
   input  logic [DATA_W-1:0]          req_file_base,
   input  logic [DATA_W-1:0]          req_file_length,
   input  logic signed [DATA_W-1:0]   req_seek_offset,
   input  logic [1:0]                 req_seek_origin,
   input  logic [DATA_W-1:0]          req_request_length,
   input  logic                       req_dest_valid,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_success,
   output logic signed [HANDLE_W-1:0] rsp_handle_out,
   output logic [DATA_W-1:0]          rsp_result_value,
   output logic [ADDR_W-1:0]          rsp_source_address
);

   localparam int IDX_W = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic                     hok_ff;
   logic                     found_ff;
   logic [DATA_W-1:0]        fbase_ff, flen_ff, offset_ff, want_ff;
   origin_type               origin_ff;
   logic                     dest_ff;
   logic [ALU_W-1:0]         acc_ff, acc_in;
   logic [DATA_W-1:0]        grant_ff, grant_in;

   logic [HANDLE_SLOTS-1:0]  used_ff;
   logic [DATA_W-1:0]        base_ff [HANDLE_SLOTS];
   logic [DATA_W-1:0]        len_ff  [HANDLE_SLOTS];
   logic [DATA_W-1:0]        pos_ff  [HANDLE_SLOTS];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_success_ff;
   logic [HANDLE_W-1:0]      rsp_handle_ff;
   logic [DATA_W-1:0]        rsp_value_ff;
   logic [ADDR_W-1:0]        rsp_src_ff;

   logic                     req_hok;
   logic                     accept;
   logic                     live;
   logic [DATA_W-1:0]        cur_base, cur_len, cur_pos;
   logic [IDX_W-1:0]         free_idx;
   logic                     free_any;
   logic                     out_free;

   logic                     fin_req, fire;
   logic                     fin_success;
   logic [HANDLE_W-1:0]      fin_handle;
   logic [DATA_W-1:0]        fin_value;
   logic [ADDR_W-1:0]        fin_src;
   logic                     wr_open, wr_close, wr_pos;
   logic                     open_req, close_req, pos_req;
   logic [DATA_W-1:0]        pos_wr_val;

   alu_req_type              alu_req;
   logic [ALU_W-1:0]         alu_sum;

   fhpt_alu u_alu (
      .alu_req (alu_req),
      .alu_sum (alu_sum)
   );

   assign req_hok = !req_handle_id[HANDLE_W-1] &&
                    ({1'b0, req_handle_id[HANDLE_W-2:0]} < HANDLE_W'(HANDLE_SLOTS));
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cur_base = base_ff[idx_ff];
   assign cur_len  = len_ff[idx_ff];
   assign cur_pos  = pos_ff[idx_ff];
   assign live     = hok_ff && used_ff[idx_ff];

   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = 0; i < HANDLE_SLOTS; i++) begin
         if (!used_ff[i] && !free_any) begin
            free_idx = IDX_W'(i);
            free_any = 1'b1;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      grant_in    = grant_ff;
      alu_req     = '0;
      fin_req     = 1'b0;
      fin_success = 1'b0;
      fin_handle  = HANDLE_NONE;
      fin_value   = '0;
      fin_src     = '0;
      open_req    = 1'b0;
      close_req   = 1'b0;
      pos_req     = 1'b0;
      pos_wr_val  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_OP1;
            end
         end
         S_OP1: begin
            case (cmd_ff) inside
               CMD_OPEN: begin
                  fin_req = 1'b1;
                  if (found_ff && free_any) begin
                     fin_success = 1'b1;
                     fin_handle  = HANDLE_W'(free_idx);
                     open_req    = 1'b1;
                  end
               end
               CMD_SIZE, CMD_TELL: begin
                  fin_req = 1'b1;
                  if (live) begin
                     fin_success = 1'b1;
                     fin_value   = (cmd_ff == CMD_SIZE) ? cur_len : cur_pos;
                  end
               end
               CMD_SEEK: begin
                  if (live && origin_ff != ORG_BAD) begin
                     unique case (origin_ff)
                        ORG_CURRENT: alu_req.a = {2'b00, cur_pos};
                        ORG_END:     alu_req.a = {2'b00, cur_len};
                        default:     alu_req.a = '0;
                     endcase
                     alu_req.b = {{2{offset_ff[DATA_W-1]}}, offset_ff};
                     acc_in    = alu_sum;
                     state_in  = S_SEEK;
                  end else begin
                     fin_req = 1'b1;
                  end
               end
               CMD_READ: begin
                  if (live && dest_ff) begin
                     alu_req.a   = {2'b00, cur_len};
                     alu_req.b   = {2'b00, cur_pos};
                     alu_req.sub = 1'b1;
                     acc_in      = alu_sum;
                     state_in    = S_CLAMP;
                  end else begin
                     fin_req = 1'b1;
                  end
               end
               CMD_CLOSE: begin
                  fin_req = 1'b1;
                  if (hok_ff) begin
                     fin_success = 1'b1;
                     close_req   = 1'b1;
                  end
               end
               default: begin
                  fin_req = 1'b1;
               end
            endcase
         end
         S_SEEK: begin
            alu_req.a   = {2'b00, cur_len};
            alu_req.b   = acc_ff;
            alu_req.sub = 1'b1;
            fin_req     = 1'b1;
            if (!acc_ff[ALU_W-1] && !alu_sum[ALU_W-1]) begin
               fin_success = 1'b1;
               pos_req     = 1'b1;
               pos_wr_val  = acc_ff[DATA_W-1:0];
            end
         end
         S_CLAMP: begin
            alu_req.a   = {2'b00, want_ff};
            alu_req.b   = acc_ff;
            alu_req.sub = 1'b1;
            if (acc_ff[ALU_W-1]) begin
               grant_in = '0;
            end else if (alu_sum[ALU_W-1]) begin
               grant_in = want_ff;
            end else begin
               grant_in = acc_ff[DATA_W-1:0];
            end
            state_in = S_SRC;
         end
         S_SRC: begin
            alu_req.a = {2'b00, cur_base};
            alu_req.b = {2'b00, cur_pos};
            acc_in    = alu_sum;
            state_in  = S_ADV;
         end
         S_ADV: begin
            alu_req.a   = {2'b00, cur_pos};
            alu_req.b   = {2'b00, grant_ff};
            fin_req     = 1'b1;
            fin_success = 1'b1;
            fin_value   = grant_ff;
            fin_src     = acc_ff[ADDR_W-1:0];
            pos_req     = 1'b1;
            pos_wr_val  = alu_sum[DATA_W-1:0];
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // hold the final step while the result register is occupied and not being taken
      fire = fin_req && out_free;
      if (fin_req) begin
         state_in = fire ? S_IDLE : state_ff;
      end
      wr_open  = fire && open_req;
      wr_close = fire && close_req;
      wr_pos   = fire && pos_req;
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         idx_ff       <= '0;
         hok_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            idx_ff <= req_handle_id[IDX_W-1:0];
            hok_ff <= req_hok;
         end
         if (wr_open) begin
            used_ff[free_idx] <= 1'b1;
         end else if (wr_close) begin
            used_ff[idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      grant_ff <= grant_in;
      if (accept) begin
         cmd_ff    <= cmd_type'(req_command);
         found_ff  <= req_file_found;
         fbase_ff  <= req_file_base;
         flen_ff   <= req_file_length;
         offset_ff <= req_seek_offset;
         origin_ff <= origin_type'(req_seek_origin);
         want_ff   <= req_request_length;
         dest_ff   <= req_dest_valid;
      end
      if (fire) begin
         rsp_success_ff <= fin_success;
         rsp_handle_ff  <= fin_handle;
         rsp_value_ff   <= fin_value;
         rsp_src_ff     <= fin_src;
      end
      if (wr_open) begin
         base_ff[free_idx] <= fbase_ff;
         len_ff[free_idx]  <= flen_ff;
         pos_ff[free_idx]  <= '0;
      end else if (wr_close) begin
         base_ff[idx_ff] <= '0;
         len_ff[idx_ff]  <= '0;
         pos_ff[idx_ff]  <= '0;
      end else if (wr_pos) begin
         pos_ff[idx_ff] <= pos_wr_val;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_success        = rsp_success_ff;
   assign rsp_handle_out     = rsp_handle_ff;
   assign rsp_result_value   = rsp_value_ff;
   assign rsp_source_address = rsp_src_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_OP1)
      else $error("accepted request did not start the sequencer");

   a_open_claims: assert property (@(posedge clock) disable iff (reset)
      wr_open |=> used_ff[$past(free_idx)])
      else $error("open did not mark its slot used");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (hok_ff && used_ff[idx_ff]) |-> pos_ff[idx_ff] <= len_ff[idx_ff])
      else $error("slot position beyond length");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_success) |->
         (rsp_result_value == '0 && rsp_source_address == '0 &&
          rsp_handle_out == HANDLE_NONE))
      else $error("failed request carries data");

endmodule
